FILE: hdl/lrinf_pkg.sv
// ----------------------------------------------------------------------------
// lrinf_pkg
// Shared types, codes and the sigmoid lookup table of the logistic
// regression inference block.
// ----------------------------------------------------------------------------
package lrinf_pkg;

  localparam int IDX_W      = 6;
  localparam int TABLE_SIZE = 1024;
  localparam int TABLE_W    = 10;
  localparam int SUM_W      = 40;
  localparam int PROD_W     = 32;

  typedef enum logic {
    FUNC_LOAD    = 1'b0,
    FUNC_FEATURE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CFG_FEATURE_COUNT = 2'd0,
    CFG_BIAS          = 2'd1,
    CFG_THRESHOLD     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               feature;
    logic               first;
    logic               last;
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] value;
  } op_t;

  typedef logic [15:0] sig_rom_t [TABLE_SIZE];

  // Restoring long division, evaluated only while the table is built.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic longint unsigned exp_q44(input int unsigned m);
    longint unsigned term;
    longint unsigned sum;
    int unsigned     n;
    term = 64'd1 << 44;
    sum  = 64'd1 << 44;
    for (n = 1; (n < 200) && (term != 64'd0); n++) begin
      term = udiv64(term * longint'(m), 64'd64 * longint'(n));
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic sig_rom_t build_sig_rom();
    sig_rom_t        rom;
    int unsigned     m;
    longint unsigned d;
    longint unsigned c;
    longint unsigned p;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      m = (k >= 512) ? (k - 512) : (512 - k);
      d = exp_q44(m) + (64'd1 << 44);
      c = udiv64((64'd1 << 61) + d, d * 64'd2);
      p = (k >= 512) ? (64'd65536 - c) : c;
      if (p > 64'd65535) begin
        p = 64'd65535;
      end
      rom[k] = p[15:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

FILE: hdl/lrinf_front.sv
// ----------------------------------------------------------------------------
// lrinf_front
// Accepts input items, drops weight writes outside the store, and tags each
// feature with its position and its first and last marks.
// ----------------------------------------------------------------------------
module lrinf_front #(
  parameter int MAX_FEATURES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,
  input  logic              in_tuser,
  input  logic [4:0]        feature_count,
  input  logic              q_full,
  output logic              push,
  output lrinf_pkg::op_t    op
);

  localparam int PW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CWM = $clog2(MAX_FEATURES + 1);
  localparam int CW  = (CWM > 5) ? CWM : 5;

  logic [PW-1:0]      pos_r;
  logic [PW-1:0]      pos_nxt;
  logic [CW-1:0]      count_eff;
  logic [CW-1:0]      pos_inc;
  logic               accept;
  logic               is_feature;
  logic               last;
  logic [3:0]         widx;
  logic signed [15:0] value;

  assign widx       = in_tdata[3:0];
  assign value      = in_tdata[19:4];
  assign is_feature = (in_tuser == lrinf_pkg::FUNC_FEATURE);
  assign in_tready  = !q_full;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    if (feature_count == 5'd0) begin
      count_eff = CW'(1);
    end else if (CW'(feature_count) > CW'(MAX_FEATURES)) begin
      count_eff = CW'(MAX_FEATURES);
    end else begin
      count_eff = CW'(feature_count);
    end
  end

  assign pos_inc = CW'(pos_r) + CW'(1);
  assign last    = (pos_inc >= count_eff);

  always_comb begin
    pos_nxt = pos_r;
    if (accept && is_feature) begin
      pos_nxt = last ? '0 : pos_inc[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    op.feature = is_feature;
    op.first   = is_feature && (pos_r == '0);
    op.last    = is_feature && last;
    op.idx     = is_feature ? lrinf_pkg::IDX_W'(pos_r) : lrinf_pkg::IDX_W'(widx);
    op.value   = value;
  end

  assign push = accept && (is_feature || (int'(widx) < MAX_FEATURES));

endmodule

FILE: hdl/lrinf_queue.sv
// ----------------------------------------------------------------------------
// lrinf_queue
// Two-entry queue of classified operations between the front and back parts.
// ----------------------------------------------------------------------------
module lrinf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lrinf_pkg::op_t push_op,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output lrinf_pkg::op_t head
);

  lrinf_pkg::op_t entry_r [2];
  logic           wr_ptr_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_r;
  logic           rd_ptr_nxt;
  logic [1:0]     cnt_r;
  logic [1:0]     cnt_nxt;
  logic           do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign head    = entry_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: hdl/lrinf_back.sv
// ----------------------------------------------------------------------------
// lrinf_back
// Weight store, multiply-accumulate, clamp, sigmoid lookup and the result
// register.
// ----------------------------------------------------------------------------
module lrinf_back #(
  parameter int MAX_FEATURES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lrinf_pkg::op_t     head,
  output logic               pop,
  input  logic signed [31:0] bias,
  input  logic [15:0]        threshold,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_prob,
  output logic               out_label
);

  localparam int PW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  logic signed [15:0]                      weight_r [MAX_FEATURES];
  logic                                    adv;
  logic                                    v1_r;
  logic                                    first1_r;
  logic                                    last1_r;
  logic signed [lrinf_pkg::PROD_W-1:0]     prod_r;
  logic signed [lrinf_pkg::SUM_W-1:0]      acc_r;
  logic signed [lrinf_pkg::SUM_W-1:0]      acc_nxt;
  logic signed [lrinf_pkg::SUM_W-1:0]      base;
  logic                                    v2_r;
  logic [lrinf_pkg::TABLE_W-1:0]           k_r;
  logic [lrinf_pkg::TABLE_W-1:0]           k_nxt;
  logic                                    v3_r;
  logic [15:0]                             rom_r;
  logic                                    out_valid_r;
  logic [15:0]                             prob_r;
  logic                                    label_r;
  logic                                    sat;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (pop && !head.feature) begin
      weight_r[head.idx[PW-1:0]] <= head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first1_r <= head.first;
      last1_r  <= head.last;
      prod_r   <= weight_r[head.idx[PW-1:0]] * head.value;
    end
  end

  always_comb begin
    base    = first1_r ? lrinf_pkg::SUM_W'(bias) : acc_r;
    acc_nxt = base + lrinf_pkg::SUM_W'(prod_r);
    sat     = (acc_nxt[lrinf_pkg::SUM_W-1:27] != '0) &&
              (acc_nxt[lrinf_pkg::SUM_W-1:27] != '1);
    if (sat) begin
      k_nxt = acc_nxt[lrinf_pkg::SUM_W-1] ? '0 : '1;
    end else begin
      k_nxt = {!acc_nxt[27], acc_nxt[26:18]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1_r) begin
      acc_r <= acc_nxt;
      k_r   <= k_nxt;
    end
    if (adv) begin
      rom_r   <= lrinf_pkg::SIG_ROM[k_r];
      prob_r  <= rom_r;
      label_r <= (rom_r >= threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_valid && head.feature;
      v2_r        <= v1_r && last1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_prob  = prob_r;
  assign out_label = label_r;

endmodule

FILE: hdl/logistic_regression_infer_top.sv
// ----------------------------------------------------------------------------
// logistic_regression_infer_top
// Binary logistic regression inference: weight loading, dot product with a
// bias, and a sigmoid table lookup with a thresholded label.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle: each feature costs one
// multiply-accumulate, and weight loads go through the same path in order,
// so a weight written just before a feature is seen by it. A result passes
// from the queue through the product, accumulator and table registers to
// the output register. While a finished result waits to be taken the
// arithmetic pipeline holds, and a two-entry queue between the input side
// and the pipeline takes up to two more items before the input closes.
// There is no clearing pass after reset; weights must be loaded before the
// features that use them.
module logistic_regression_infer_top #(
  parameter int MAX_FEATURES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // weight_index [3:0], value [19:4], zero [23:20]
  input  logic        in_tuser,   // func [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // probability [15:0], label [16], zero [23:17]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [4:0]         feature_count_r;
  logic signed [31:0] bias_r;
  logic [15:0]        threshold_r;
  logic               push;
  lrinf_pkg::op_t     push_op;
  logic               q_full;
  logic               q_valid;
  lrinf_pkg::op_t     head;
  logic               pop;
  logic [15:0]        prob;
  logic               label;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_count_r <= 5'd16;
      bias_r          <= '0;
      threshold_r     <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrinf_pkg::CFG_FEATURE_COUNT: feature_count_r <= cfg_wdata[4:0];
        lrinf_pkg::CFG_BIAS:          bias_r          <= cfg_wdata;
        lrinf_pkg::CFG_THRESHOLD:     threshold_r     <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  lrinf_front #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .feature_count (feature_count_r),
    .q_full        (q_full),
    .push          (push),
    .op            (push_op)
  );

  lrinf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .head    (head)
  );

  lrinf_back #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .bias      (bias_r),
    .threshold (threshold_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_prob  (prob),
    .out_label (label)
  );

  assign out_tdata = {7'd0, label, prob};

endmodule

FILE: hdl/lrinf_checker.sv
// ----------------------------------------------------------------------------
// lrinf_checker
// Port-level checks of the logistic regression inference block.
// ----------------------------------------------------------------------------
module lrinf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or was dropped.");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("Input not ready right after reset.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:17] == 7'd0))
    else $error("Result padding bits not zero.");

endmodule

bind logistic_regression_infer_top lrinf_checker u_lrinf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: dv/logistic_regression_infer_top_tb.sv
// ----------------------------------------------------------------------------
// logistic_regression_infer_top_tb
// Self-checking bench for the logistic regression inference block. Weights
// and features are streamed in with random gaps while results are taken with
// random stalls. Each accepted item is scored by a local dot product and
// sigmoid model, and every result is compared against the oldest prediction.
// Register writes happen only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module logistic_regression_infer_top_tb;

  localparam int NUM_WEIGHTS = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam longint Z_CLAMP = 64'sd134217728;

  typedef struct {
    lrinf_pkg::func_t   func;
    logic [3:0]         widx;
    logic signed [15:0] value;
  } lr_item_t;

  typedef struct {
    logic [15:0] prob;
    logic        label;
  } lr_score_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  lr_item_t  feed_q[$];
  lr_score_t score_q[$];
  lr_item_t  cur_item;

  logic [15:0]        sig_lut [1024];
  logic signed [15:0] weights [NUM_WEIGHTS];
  logic [4:0]         cfg_count = 5'd16;
  logic [31:0]        cfg_bias = '0;
  logic [15:0]        cfg_thr = 16'd32768;
  longint             dot_sum = 0;
  int                 feat_pos = 0;

  int idle_pct = 15;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  logistic_regression_infer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned exp_series(int unsigned m);
    longint unsigned term;
    longint unsigned acc;
    int unsigned     n;
    term = 64'd1 << 44;
    acc  = term;
    for (n = 1; (n < 200) && (term != 64'd0); n++) begin
      term = (term * 64'(m)) / (64'd64 * 64'(n));
      acc  = acc + term;
    end
    return acc;
  endfunction

  function automatic logic [15:0] sigmoid_entry(int k);
    int unsigned     m;
    longint unsigned d;
    longint unsigned c;
    longint unsigned p;
    m = (k >= 512) ? (k - 512) : (512 - k);
    d = exp_series(m) + (64'd1 << 44);
    c = ((64'd1 << 61) + d) / (d * 64'd2);
    p = (k >= 512) ? (64'd65536 - c) : c;
    if (p > 64'd65535) begin
      p = 64'd65535;
    end
    return p[15:0];
  endfunction

  function automatic logic signed [15:0] rand_q412();
    int v;
    case ($urandom_range(9))
      0: v = -32768;
      1: v = 32767;
      2, 3: v = $urandom_range(65535);
      default: v = $urandom_range(4095) - 2048;
    endcase
    return v[15:0];
  endfunction

  function automatic int eff_count();
    if (cfg_count == 5'd0) begin
      return 1;
    end
    if (cfg_count > NUM_WEIGHTS) begin
      return NUM_WEIGHTS;
    end
    return int'(cfg_count);
  endfunction

  // Updates the local copy of the weights and the running sum for one item,
  // and queues a probability and label when a sample completes.
  task automatic score_item(lr_item_t it);
    int        p;
    longint    z;
    int        k;
    lr_score_t s;
    if (it.func == lrinf_pkg::FUNC_LOAD) begin
      weights[it.widx] = it.value;
    end else begin
      p = (feat_pos >= NUM_WEIGHTS) ? NUM_WEIGHTS - 1 : feat_pos;
      if (feat_pos == 0) begin
        dot_sum = longint'(signed'(cfg_bias));
      end
      dot_sum = dot_sum + longint'(weights[p]) * longint'(it.value);
      feat_pos++;
      if (feat_pos >= eff_count()) begin
        z = dot_sum;
        if (z < -Z_CLAMP) begin
          z = -Z_CLAMP;
        end
        if (z > Z_CLAMP - 1) begin
          z = Z_CLAMP - 1;
        end
        k = int'(((z + Z_CLAMP) >>> 18) & 64'd1023);
        s.prob  = sig_lut[k];
        s.label = (s.prob >= cfg_thr);
        score_q.push_back(s);
        dot_sum  = 0;
        feat_pos = 0;
      end
    end
  endtask

  task automatic push_load(int idx, logic signed [15:0] v);
    lr_item_t it;
    it.func  = lrinf_pkg::FUNC_LOAD;
    it.widx  = idx[3:0];
    it.value = v;
    feed_q.push_back(it);
  endtask

  task automatic push_feature(logic signed [15:0] v);
    lr_item_t it;
    it.func  = lrinf_pkg::FUNC_FEATURE;
    it.widx  = 4'($urandom_range(15));
    it.value = v;
    feed_q.push_back(it);
  endtask

  task automatic push_sample(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        push_load($urandom_range(15), rand_q412());
      end
      push_feature(rand_q412());
    end
  endtask

  // Blocks until every item is accepted and every result is back, then lets
  // the pipeline run empty.
  task automatic settle();
    while ((feed_q.size() != 0) || in_tvalid || (score_q.size() != 0)) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lrinf_pkg::cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lrinf_pkg::CFG_FEATURE_COUNT: cfg_count = v[4:0];
      lrinf_pkg::CFG_BIAS:          cfg_bias  = v;
      lrinf_pkg::CFG_THRESHOLD:     cfg_thr   = v[15:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        score_item(cur_item);
      end
      if (!in_tvalid || in_tready) begin
        if ((feed_q.size() != 0) && ($urandom_range(99) >= idle_pct)) begin
          cur_item = feed_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, cur_item.value, cur_item.widx};
          in_tuser  <= cur_item.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lr_score_t s;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
      if (out_tvalid && out_tready) begin
        if (score_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual probability %0d label %0d",
                   $time, out_tdata[15:0], out_tdata[16]);
          mismatch_count++;
        end else begin
          s = score_q.pop_front();
          if (out_tdata[15:0] !== s.prob) begin
            $display("%0t: probability mismatch, expected %0d, actual %0d",
                     $time, s.prob, out_tdata[15:0]);
            mismatch_count++;
          end
          if (out_tdata[16] !== s.label) begin
            $display("%0t: label mismatch, expected %0d, actual %0d",
                     $time, s.label, out_tdata[16]);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress on either channel", $time);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int          n;
    int          r;
    int          c;
    logic [31:0] b;
    for (int k = 0; k < 1024; k++) begin
      sig_lut[k] = sigmoid_entry(k);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every weight written first, then saturated scores, a
    // zero score landing exactly on the threshold, and a weight reloaded
    // in the middle of a sample.
    write_reg(lrinf_pkg::CFG_FEATURE_COUNT, 32'd2);
    push_load(0, 16'sh7FFF);
    push_load(1, -16'sh8000);
    push_load(2, 16'sh0000);
    push_load(3, 16'sh0001);
    push_load(4, -16'sh0001);
    for (int i = 5; i < NUM_WEIGHTS; i++) begin
      push_load(i, rand_q412());
    end
    push_feature(16'sh7FFF);
    push_feature(-16'sh8000);
    push_feature(-16'sh8000);
    push_feature(16'sh7FFF);
    push_feature(16'sh0000);
    push_feature(16'sh0000);
    push_feature(rand_q412());
    push_load(1, rand_q412());
    push_feature(rand_q412());
    settle();

    // The bias is latched by the first feature of a sample.
    write_reg(lrinf_pkg::CFG_BIAS, 32'h0100_0000);
    push_feature(16'sh1000);
    settle();
    write_reg(lrinf_pkg::CFG_BIAS, 32'hFD00_0000);
    push_feature(16'sh1000);
    settle();

    // Lowering the count below the position ends the sample on the next
    // feature.
    write_reg(lrinf_pkg::CFG_FEATURE_COUNT, 32'd4);
    push_sample(3);
    settle();
    write_reg(lrinf_pkg::CFG_FEATURE_COUNT, 32'd2);
    push_feature(rand_q412());
    settle();

    // Counts outside the legal range.
    write_reg(lrinf_pkg::CFG_FEATURE_COUNT, 32'd0);
    push_sample(2);
    settle();
    write_reg(lrinf_pkg::CFG_FEATURE_COUNT, 32'd31);
    push_sample(NUM_WEIGHTS);
    settle();

    for (int ph = 0; ph < 24; ph++) begin
      idle_pct = ((ph >= 10) && (ph < 13)) ? 0 : 15;
      case (ph)
        0: begin
          write_reg(lrinf_pkg::CFG_FEATURE_COUNT, 32'd1);
          write_reg(lrinf_pkg::CFG_BIAS, 32'h7FFF_FFFF);
          write_reg(lrinf_pkg::CFG_THRESHOLD, 32'd0);
        end
        1: begin
          write_reg(lrinf_pkg::CFG_FEATURE_COUNT, 32'd16);
          write_reg(lrinf_pkg::CFG_BIAS, 32'h8000_0000);
          write_reg(lrinf_pkg::CFG_THRESHOLD, 32'd65535);
        end
        2: begin
          write_reg(lrinf_pkg::CFG_BIAS, 32'd0);
          write_reg(lrinf_pkg::CFG_THRESHOLD, 32'd32768);
        end
        default: begin
          if ($urandom_range(2) != 0) begin
            c = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
            write_reg(lrinf_pkg::CFG_FEATURE_COUNT, 32'(c));
          end
          if ($urandom_range(1) != 0) begin
            b = ($urandom_range(3) == 0) ? $urandom :
                32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
            write_reg(lrinf_pkg::CFG_BIAS, b);
          end
          if ($urandom_range(1) != 0) begin
            write_reg(lrinf_pkg::CFG_THRESHOLD, 32'($urandom_range(65535)));
          end
        end
      endcase
      n = 0;
      while (n < 72) begin
        r = $urandom_range(99);
        if (r < 8) begin
          push_load($urandom_range(15), rand_q412());
          n++;
        end else if (r < 12) begin
          push_feature(rand_q412());
          n++;
        end else begin
          push_sample(eff_count());
          n += eff_count();
        end
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
